>>> rtl/gsnp_pkg.sv
// Package for the grid snap nearest point block: constants, codes, types.
// No dependencies.
package gsnp_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned IVL_W = 31;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] PLANE_XY   = 2'd0;
    localparam logic [1:0] PLANE_YZ   = 2'd1;
    localparam logic [1:0] PLANE_XZ   = 2'd2;
    localparam logic [1:0] PLANE_NONE = 2'd3;

    localparam logic [1:0] SRC_INPUT  = 2'd0;
    localparam logic [1:0] SRC_GRID   = 2'd1;
    localparam logic [1:0] SRC_STORED = 2'd2;

    localparam logic [1:0] REG_PLANE    = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_OFFSET   = 2'd2;

    // divider: 34-bit magnitude by 32-bit divisor, one quotient bit a cycle
    localparam int unsigned DIV_N_W = 34;
    localparam int unsigned DIV_D_W = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV0,
        ST_MUL0,
        ST_DIV1,
        ST_MUL1,
        ST_GDIST,
        ST_READ,
        ST_CMP,
        ST_DONE
    } state_t;

    // divider handshake
    typedef struct packed {
        logic                 start;
        logic [DIV_N_W-1:0]   num;
        logic [DIV_D_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_N_W-1:0]   quo;
    } div_rsp_t;

endpackage

>>> rtl/grid_snap_nearest_point_top.sv
// Top level of the grid snap nearest point block: sequencer, point table,
// shared multiplier. Depends on gsnp_pkg and gsnp_divider.
//
// Usage: pulse start with cmd and coordinates while busy is low. Clear and
// add are taken in the accepting cycle: busy stays low and the next request
// can follow on the next edge; they give no result. A query snaps the two
// plane axes, each a 34-bit bit-serial division followed by a multiply
// step; then two squaring steps for the grid distance and, per stored
// point, a table read and two squaring steps through the one shared 34x34
// multiplier, and a result cycle, the last busy cycle, with done high.
// Plane none is busy for one cycle, the result cycle. The result appears
// for one cycle with done high and cannot be stalled.
module grid_snap_nearest_point_top #(
    parameter int unsigned TABLE_DEPTH = gsnp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    output logic                done,
    output logic signed [31:0]  snap_x,
    output logic signed [31:0]  snap_y,
    output logic signed [31:0]  snap_z,
    output logic [1:0]          snap_source,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import gsnp_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // configuration registers
    logic [1:0]         plane_reg;
    logic [IVL_W-1:0]   ivl_reg;
    logic signed [31:0] off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= PLANE_XY;
            ivl_reg   <= IVL_W'(65536);
            off_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLANE:    plane_reg <= cfg_data[1:0];
                REG_INTERVAL: ivl_reg   <= cfg_data[IVL_W-1:0];
                REG_OFFSET:   off_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // state
    state_t state_reg, state_next;
    logic signed [31:0] q_reg [3];
    logic signed [31:0] r_reg [3], r_next [3];
    logic [1:0]         src_reg, src_next;
    logic               neg_reg, neg_next;
    logic [65:0]        acc_reg, acc_next;   // running sum of squares
    logic [65:0]        best_reg, best_next;
    logic               half_reg, half_next; // second squaring step
    logic signed [32:0] d1_reg, d1_next;

    // divider run flag and captured quotient
    logic        div_run_reg;
    logic [32:0] q_quo_reg;

    // point table memory
    logic [95:0] mem [TABLE_DEPTH];
    logic [95:0] rd_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          wr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= {coord_x, coord_y, coord_z};
        if (state_reg == ST_READ)
            rd_reg <= mem[idx_reg[AW-1:0]];
    end

    // plane axis selection
    logic [1:0] p0, p1, po;
    always_comb
    begin
        case (plane_reg)
            PLANE_YZ: begin p0 = 2'd1; p1 = 2'd2; po = 2'd0; end
            PLANE_XZ: begin p0 = 2'd0; p1 = 2'd2; po = 2'd1; end
            default:  begin p0 = 2'd0; p1 = 2'd1; po = 2'd2; end
        endcase
    end

    logic [31:0] ivl_eff;
    assign ivl_eff = (ivl_reg == '0) ? 32'd1 : {1'b0, ivl_reg};

    // divider
    div_req_t dreq;
    div_rsp_t drsp;
    gsnp_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // shared multiplier: 34x34 signed
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic signed [31:0] stored [3];
    assign stored[0] = rd_reg[95:64];
    assign stored[1] = rd_reg[63:32];
    assign stored[2] = rd_reg[31:0];

    logic signed [33:0] t_sel;
    logic [33:0]        t_mag;
    logic signed [66:0] recon;
    logic signed [31:0] sat;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start && !busy)
                begin
                    if (cmd == CMD_QUERY)
                        state_next = (plane_reg == PLANE_NONE) ? ST_DONE : ST_DIV0;
                    else
                        state_next = ST_IDLE;
                end
            ST_DIV0:  if (drsp.done) state_next = ST_MUL0;
            ST_MUL0:  state_next = ST_DIV1;
            ST_DIV1:  if (drsp.done) state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_GDIST;
            ST_GDIST: if (half_reg)
                          state_next = (count_reg == '0) ? ST_DONE : ST_READ;
            ST_READ:  state_next = ST_CMP;
            ST_CMP:   if (half_reg)
                          state_next = (idx_reg == count_reg) ? ST_DONE : ST_READ;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        r_next     = r_reg;
        src_next   = src_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        best_next  = best_reg;
        half_next  = 1'b0;
        d1_next    = d1_reg;
        wr_en      = 1'b0;
        dreq       = '0;
        mul_a      = '0;
        mul_b      = '0;
        t_sel      = '0;
        t_mag      = '0;
        recon      = '0;
        sat        = '0;
        case (state_reg)
            ST_IDLE:
                if (start && !busy)
                begin
                    if (cmd == CMD_CLEAR)
                        count_next = '0;
                    else if (cmd == CMD_ADD && count_reg < CW'(TABLE_DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else if (cmd == CMD_QUERY)
                    begin
                        // result starts as the query point itself
                        r_next[0] = coord_x;
                        r_next[1] = coord_y;
                        r_next[2] = coord_z;
                        src_next  = (plane_reg == PLANE_NONE) ? SRC_INPUT : SRC_GRID;
                    end
                end
            default: ;
        endcase

        // start division on entering a divide state, while the divider is not running
        if ((state_reg == ST_DIV0 || state_reg == ST_DIV1) && !div_run_reg)
        begin
            t_sel = (state_reg == ST_DIV0) ? 34'(q_reg[p0]) + 34'(off_reg)
                                           : 34'(q_reg[p1]) + 34'(off_reg);
            t_mag = t_sel[33] ? 34'(-t_sel) : t_sel;
            neg_next  = t_sel[33];
            dreq.start = 1'b1;
            dreq.num   = {t_mag[32:0], 1'b0} + 34'(ivl_eff);
            dreq.den   = {ivl_eff[30:0], 1'b0};
        end

        // multiply quotient back, de-offset, saturate
        if (state_reg == ST_MUL0 || state_reg == ST_MUL1)
        begin
            mul_a = $signed({1'b0, q_quo_reg});
            mul_b = $signed({2'b00, ivl_eff});
            recon = neg_reg ? -67'(mul_p) : 67'(mul_p);
            recon = recon - 67'(off_reg);
            if (recon > 67'sd2147483647)       sat = 32'h7FFF_FFFF;
            else if (recon < -67'sd2147483648) sat = 32'h8000_0000;
            else                               sat = recon[31:0];
            if (state_reg == ST_MUL0) r_next[p0] = sat;
            else                      r_next[p1] = sat;
        end

        // grid distance, two squaring steps
        if (state_reg == ST_GDIST)
        begin
            mul_a = half_reg ? 34'(d1_reg) : 34'(33'(q_reg[p0]) - 33'(r_reg[p0]));
            mul_b = mul_a;
            if (!half_reg)
            begin
                d1_next   = 33'(q_reg[p1]) - 33'(r_reg[p1]);
                acc_next  = 66'(mul_p);
                half_next = 1'b1;
            end
            else
            begin
                best_next = acc_reg + 66'(mul_p);
                idx_next  = '0;
            end
        end

        if (state_reg == ST_READ)
            idx_next = idx_reg + CW'(1);

        // stored point compare
        if (state_reg == ST_CMP)
        begin
            mul_a = half_reg ? 34'(d1_reg) : 34'(33'(q_reg[p0]) - 33'(stored[p0]));
            mul_b = mul_a;
            if (!half_reg)
            begin
                d1_next   = 33'(q_reg[p1]) - 33'(stored[p1]);
                acc_next  = 66'(mul_p);
                half_next = 1'b1;
            end
            else if (stored[po] == q_reg[po] &&
                     (acc_reg + 66'(mul_p)) < best_reg)
            begin
                best_next = acc_reg + 66'(mul_p);
                r_next    = stored;
                src_next  = SRC_STORED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            half_reg    <= 1'b0;
            div_run_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            half_reg  <= half_next;
            if (dreq.start)     div_run_reg <= 1'b1;
            else if (drsp.done) div_run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        src_reg  <= src_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        best_reg <= best_next;
        d1_reg   <= d1_next;
        if (drsp.done)
            q_quo_reg <= drsp.quo[32:0];
        if (state_reg == ST_IDLE && start && !busy)
        begin
            q_reg[0] <= coord_x;
            q_reg[1] <= coord_y;
            q_reg[2] <= coord_z;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_DONE);
    assign snap_x      = r_reg[0];
    assign snap_y      = r_reg[1];
    assign snap_z      = r_reg[2];
    assign snap_source = src_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH)) else $error("table count overflow");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe longer than one cycle");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !dreq.start) else $error("divider started idle");
    a_src_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (snap_source != 2'd3)) else $error("bad source code");

endmodule

>>> rtl/gsnp_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gsnp_pkg.
module gsnp_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  gsnp_pkg::div_req_t req,
    output gsnp_pkg::div_rsp_t rsp
);
    import gsnp_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W:0]   rem_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W+1:0] diff;

    // shift in next numerator bit and try subtract
    always_comb
    begin
        trial = {rem_reg[DIV_D_W-1:0], quo_reg[DIV_N_W-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_D_W+1])
            begin
                rem_reg <= diff[DIV_D_W:0];
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule
